// File: hdl/vasm_pkg.sv
// Shared constants and helper functions for the voice allocating saturating mixer.
// No dependencies; imported by every module of the mixer.
package vasm_pkg;

    // Default sizes, handed to the top level parameters.
    localparam int DEF_NUM_VOICES  = 8;
    localparam int DEF_STORE_WORDS = 4096;

    // Fixed field widths of the transaction ports.
    localparam int KIND_W  = 2;
    localparam int ADDR_W  = 12;
    localparam int WORD_W  = 16;
    localparam int LEN_W   = 13;
    localparam int TIME_W  = 32;
    localparam int VOICE_W = 3;
    localparam int MASK_W  = 8;

    // Item kind codes.
    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PLAY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

    // Saturation limits of the mix accumulator.
    localparam logic signed [WORD_W-1:0] SAT_MAX = 16'sh7fff;
    localparam logic signed [WORD_W-1:0] SAT_MIN = 16'sh8000;

    // Reduces a 12-bit address modulo the store depth. The depth is at least 256,
    // so the quotient is below 16 and four conditional subtractions suffice.
    function automatic int f_mod_store(input logic [ADDR_W-1:0] x, input int n);
        int r;
        r = int'(x);
        for (int k = 3; k >= 0; k--) begin
            if (r >= (n << k)) begin
                r = r - (n << k);
            end
        end
        return r;
    endfunction

    // Signed 16-bit add that clamps to the 16-bit range on overflow.
    function automatic logic signed [WORD_W-1:0] f_sat_add(
        input logic signed [WORD_W-1:0] a,
        input logic signed [WORD_W-1:0] b
    );
        logic signed [WORD_W:0] s;
        s = $signed({a[WORD_W-1], a}) + $signed({b[WORD_W-1], b});
        if (s[WORD_W] != s[WORD_W-1]) begin
            return s[WORD_W] ? SAT_MIN : SAT_MAX;
        end
        return s[WORD_W-1:0];
    endfunction

endpackage

// File: hdl/vasm_store.sv
// Sample store: one write port and one read port with a registered read.
// Depends on vasm_pkg for the word width and default depth.
module vasm_store #(
    parameter int STORE_WORDS = vasm_pkg::DEF_STORE_WORDS,
    localparam int AW = $clog2(STORE_WORDS)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [vasm_pkg::WORD_W-1:0] i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [vasm_pkg::WORD_W-1:0] o_rdata
);
    import vasm_pkg::*;

    logic [WORD_W-1:0] r_mem [STORE_WORDS];
    logic [WORD_W-1:0] r_rdata;

    // Write and registered read of the sample words.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/vasm_voice_table.sv
// Voice table: read address, words left and start time for every voice.
// One write port and one registered read port; depends on vasm_pkg.
module vasm_voice_table #(
    parameter int NUM_VOICES = vasm_pkg::DEF_NUM_VOICES,
    parameter int ENTRY_W    = 57,
    localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [VW-1:0]      i_waddr,
    input  logic [ENTRY_W-1:0] i_wdata,
    input  logic [VW-1:0]      i_raddr,
    output logic [ENTRY_W-1:0] o_rdata
);
    import vasm_pkg::*;

    logic [ENTRY_W-1:0] r_mem [NUM_VOICES];
    logic [ENTRY_W-1:0] r_rdata;

    // Write and registered read of the voice entries.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/voice_allocating_saturating_mixer_unit.sv
// Top level of the voice allocating saturating mixer: sequencer, active flags, result register.
// Depends on vasm_pkg, vasm_store and vasm_voice_table.
//
//  Channel | Handshake          | Payload
//  --------+--------------------+---------------------------------------------------------
//  input   | i_valid / o_ready  | i_kind, i_mem_addr, i_mem_word, i_sample_base,
//          |                    | i_sample_len, i_start_time
//  result  | o_valid / i_ready  | o_mixed_sample, o_voice, o_stole_voice, o_active_mask
//
// A load gives no result. A play that finds a free voice goes straight to the done state;
// a play that must steal first scans the voice table for the smallest start time.
// A tick reads the voice table once per voice through a three-stage read, store fetch
// and accumulate pipeline.
// Synchronous active-low reset clears the active flags and the control state; the
// sample store holds no reset value. A stalled result waits in the output register
// while the next transaction is already accepted.
module voice_allocating_saturating_mixer_unit #(
    parameter int NUM_VOICES  = vasm_pkg::DEF_NUM_VOICES,
    parameter int STORE_WORDS = vasm_pkg::DEF_STORE_WORDS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [vasm_pkg::KIND_W-1:0]        i_kind,
    input  logic [vasm_pkg::ADDR_W-1:0]        i_mem_addr,
    input  logic signed [vasm_pkg::WORD_W-1:0] i_mem_word,
    input  logic [vasm_pkg::ADDR_W-1:0]        i_sample_base,
    input  logic [vasm_pkg::LEN_W-1:0]         i_sample_len,
    input  logic [vasm_pkg::TIME_W-1:0]        i_start_time,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [vasm_pkg::WORD_W-1:0] o_mixed_sample,
    output logic [vasm_pkg::VOICE_W-1:0]       o_voice,
    output logic                               o_stole_voice,
    output logic [vasm_pkg::MASK_W-1:0]        o_active_mask
);
    import vasm_pkg::*;

    localparam int SAW = $clog2(STORE_WORDS);
    localparam int VW  = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int CW  = $clog2(NUM_VOICES + 1);
    localparam int EW  = SAW + LEN_W + TIME_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_TICK,
        S_DONE
    } t_state;

    t_state                     r_state;
    logic [NUM_VOICES-1:0]      r_active;
    logic [CW-1:0]              r_cnt;
    logic                       r_s1_vld;
    logic [VW-1:0]              r_s1_idx;
    logic                       r_s2_add;
    logic signed [WORD_W-1:0]   r_acc;
    logic [SAW-1:0]             r_base;
    logic [LEN_W-1:0]           r_len;
    logic [TIME_W-1:0]          r_start;
    logic [VW-1:0]              r_old_idx;
    logic [TIME_W-1:0]          r_old_start;
    logic [VW-1:0]              r_res_voice;
    logic                       r_res_stole;
    logic signed [WORD_W-1:0]   r_res_sample;
    logic                       r_out_valid;
    logic signed [WORD_W-1:0]   r_out_sample;
    logic [VOICE_W-1:0]         r_out_voice;
    logic                       r_out_stole;
    logic [MASK_W-1:0]          r_out_mask;

    logic                       in_acc;
    logic                       free_any;
    logic [VW-1:0]              free_idx;
    logic                       issue;
    logic [SAW-1:0]             in_base_mod;
    logic                       st_we;
    logic [SAW-1:0]             st_waddr;
    logic [WORD_W-1:0]          st_rdata;
    logic                       vt_we;
    logic [VW-1:0]              vt_waddr;
    logic [EW-1:0]              vt_wdata;
    logic [EW-1:0]              vt_rdata;
    logic [SAW-1:0]             rd_addr;
    logic [LEN_W-1:0]           rd_left;
    logic [TIME_W-1:0]          rd_start;
    logic [SAW-1:0]             rd_addr_next;
    logic                       s1_play;
    logic                       scan_take;
    logic [VW-1:0]              scan_pick;
    logic                       scan_last;

    assign in_acc = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);
    assign issue = (r_cnt < CW'(NUM_VOICES));

    // Lowest-numbered free voice.
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int v = NUM_VOICES - 1; v >= 0; v--) begin
            if (!r_active[v]) begin
                free_any = 1'b1;
                free_idx = VW'(v);
            end
        end
    end

    // Address reduction into the store range for loads and plays.
    assign in_base_mod = SAW'(f_mod_store(i_sample_base, STORE_WORDS));
    assign st_we       = in_acc && (i_kind == KIND_LOAD);
    assign st_waddr    = SAW'(f_mod_store(i_mem_addr, STORE_WORDS));

    // Fields of the voice entry read in the previous cycle.
    assign rd_addr  = vt_rdata[EW-1 -: SAW];
    assign rd_left  = vt_rdata[TIME_W +: LEN_W];
    assign rd_start = vt_rdata[TIME_W-1:0];

    // Next read address wraps at the end of the store.
    assign rd_addr_next = (int'(rd_addr) == STORE_WORDS - 1) ? '0 : rd_addr + 1'b1;
    assign s1_play = (r_state == S_TICK) && r_s1_vld && r_active[r_s1_idx] &&
                     (rd_left != '0);

    // Oldest-voice search: strict compare keeps the lowest index on ties.
    assign scan_take = (r_s1_idx == '0) || (rd_start < r_old_start);
    assign scan_pick = scan_take ? r_s1_idx : r_old_idx;
    assign scan_last = r_s1_vld && (r_s1_idx == VW'(NUM_VOICES - 1));

    // Voice table write: a new voice on a play, the stolen voice at the end of a scan, or the advanced voice on a tick.
    always_comb begin
        vt_we    = 1'b0;
        vt_waddr = r_s1_idx;
        vt_wdata = {rd_addr_next, rd_left - 1'b1, rd_start};
        if (r_state == S_IDLE && in_acc && i_kind == KIND_PLAY && free_any) begin
            vt_we    = 1'b1;
            vt_waddr = free_idx;
            vt_wdata = {in_base_mod, i_sample_len, i_start_time};
        end else if (r_state == S_SCAN && scan_last) begin
            vt_we    = 1'b1;
            vt_waddr = scan_pick;
            vt_wdata = {r_base, r_len, r_start};
        end else if (s1_play) begin
            vt_we = 1'b1;
        end
    end

    vasm_store #(
        .STORE_WORDS(STORE_WORDS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (st_we),
        .i_waddr(st_waddr),
        .i_wdata(i_mem_word),
        .i_raddr(rd_addr),
        .o_rdata(st_rdata)
    );

    vasm_voice_table #(
        .NUM_VOICES(NUM_VOICES),
        .ENTRY_W   (EW)
    ) u_voice_table (
        .i_clk  (i_clk),
        .i_we   (vt_we),
        .i_waddr(vt_waddr),
        .i_wdata(vt_wdata),
        .i_raddr(r_cnt[VW-1:0]),
        .o_rdata(vt_rdata)
    );

    // Sequencer, active flags and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_cnt       <= '0;
            r_s1_vld    <= 1'b0;
            r_s2_add    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // The done state reloads the output register itself.
            if (r_out_valid && i_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_base   <= in_base_mod;
                        r_len    <= i_sample_len;
                        r_start  <= i_start_time;
                        r_cnt    <= '0;
                        r_acc    <= '0;
                        r_s1_vld <= 1'b0;
                        r_s2_add <= 1'b0;
                        unique case (i_kind)
                            KIND_PLAY: begin
                                if (free_any) begin
                                    r_active[free_idx] <= 1'b1;
                                    r_res_voice        <= free_idx;
                                    r_res_stole        <= 1'b0;
                                    r_res_sample       <= '0;
                                    r_state            <= S_DONE;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            KIND_TICK: begin
                                r_state <= S_TICK;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // Every voice is active here; look for the smallest start time.
                    if (issue) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_s1_vld <= issue;
                    r_s1_idx <= r_cnt[VW-1:0];
                    if (r_s1_vld) begin
                        r_old_idx   <= scan_pick;
                        r_old_start <= scan_take ? rd_start : r_old_start;
                        if (scan_last) begin
                            r_res_voice  <= scan_pick;
                            r_res_stole  <= 1'b1;
                            r_res_sample <= '0;
                            r_state      <= S_DONE;
                        end
                    end
                end
                S_TICK: begin
                    // Stage 0 reads the voice, stage 1 fetches its word, stage 2 mixes.
                    if (issue) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_s1_vld <= issue;
                    r_s1_idx <= r_cnt[VW-1:0];
                    if (r_s1_vld && r_active[r_s1_idx] && rd_left <= LEN_W'(1)) begin
                        r_active[r_s1_idx] <= 1'b0;
                    end
                    r_s2_add <= s1_play;
                    if (r_s2_add) begin
                        r_acc <= f_sat_add(r_acc, $signed(st_rdata));
                    end
                    if (!issue && !r_s1_vld && !r_s2_add) begin
                        r_res_voice  <= '0;
                        r_res_stole  <= 1'b0;
                        r_res_sample <= r_acc;
                        r_state      <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_sample <= r_res_sample;
                        r_out_voice  <= VOICE_W'(r_res_voice);
                        r_out_stole  <= r_res_stole;
                        r_out_mask   <= MASK_W'(r_active);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_mixed_sample = r_out_sample;
    assign o_voice        = r_out_voice;
    assign o_stole_voice  = r_out_stole;
    assign o_active_mask  = r_out_mask;

    // The tick pipeline has drained before any result is handed on.
    a_drained_at_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |-> !r_s1_vld && !r_s2_add)
        else $error("mixer pipeline not drained at result");

    // A steal happens only when every voice was busy, and it leaves them all busy.
    a_steal_all_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_stole_voice |-> o_active_mask == MASK_W'({NUM_VOICES{1'b1}}))
        else $error("voice stolen while a voice was free");

    // Mixing only follows a voice fetch made during a tick.
    a_mix_in_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_add |-> $past(r_state) == S_TICK && $past(r_s1_vld))
        else $error("mix step without a voice fetch");

endmodule
